// File: design/ppa_pkg.sv
// ppa_pkg: types, widths and constants shared by the polygon area and perimeter block
// no dependencies; used by ppa_sqrt and polygon_area_perimeter_core
`timescale 1ns / 1ps

package ppa_pkg;

    // sizing of the job
    localparam int MAX_POINTS = 65536;
    localparam int COORD_BITS = 20;
    localparam int FRAC_BITS  = 8;

    // fixed port field widths
    localparam int IN_COORD_W = 20;
    localparam int PERIM_W    = 45;
    localparam int TWICE_W    = 56;
    localparam int AREA_W     = 57;

    // derived datapath widths
    localparam int DX_W       = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DX_W;
    localparam int SQ_W       = 2 * COORD_BITS + 1;
    localparam int RAD_W      = SQ_W + 2 * FRAC_BITS;
    localparam int ROOT_W     = (RAD_W + 1) / 2;
    localparam int ROOT_CNT_W = $clog2(ROOT_W);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DX_W-1:0]       diff_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic [SQ_W-1:0]              sq_t;
    typedef logic [2*ROOT_W-1:0]          rad_t;
    typedef logic [ROOT_W-1:0]            root_t;
    typedef logic signed [AREA_W-1:0]     area_t;
    typedef logic [PERIM_W-1:0]           perim_t;
    typedef logic [CNT_W-1:0]             cnt_t;

    typedef struct packed {
        logic signed [IN_COORD_W-1:0] x_coord;
        logic signed [IN_COORD_W-1:0] y_coord;
        logic                         part_last;
        logic                         polygon_last;
    } vertex_t;

    typedef struct packed {
        logic [PERIM_W-1:0] perimeter;
        logic [TWICE_W-1:0] twice_area;
        logic               overflow;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CROSS_A,
        ST_CROSS_B,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_SUM,
        ST_ROOT,
        ST_ROOT_WAIT,
        ST_EMIT
    } state_t;

    localparam perim_t PERIM_MAX = '1;
    localparam logic [TWICE_W-1:0] TWICE_MAX = '1;
    localparam logic signed [AREA_W:0] AREA_HI = {2'b00, {(AREA_W-1){1'b1}}};
    localparam logic signed [AREA_W:0] AREA_LO = {2'b11, {(AREA_W-1){1'b0}}};

endpackage

// File: design/polygon_area_perimeter_core.sv
// polygon_area_perimeter_core: shoelace area and perimeter of a polygon, one vertex per transfer
// a vertex with no edge is handled in the idle step alone; each edge adds 6 steps
// (four products on the shared multiplier, a sum and the root start),
// then ROOT_W = 29 root iterations plus handoff
// no new vertex is taken while the shared multiplier and root unit work on an edge,
// nor while the emit step waits on result_stall
// the result for polygon_last goes to an output register from the emit step, after the last edge
// reset: asynchronous active-low rst_n clears all sums, the open part and the output valid flag
`timescale 1ns / 1ps

module polygon_area_perimeter_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              vertex_valid,
    output logic              vertex_stall,
    input  ppa_pkg::vertex_t  vertex,
    output logic              result_valid,
    input  logic              result_stall,
    output ppa_pkg::result_t  result
);

    // sequencer
    ppa_pkg::state_t state_reg, state_next;

    // polygon state
    ppa_pkg::coord_t first_x_reg, first_x_next;
    ppa_pkg::coord_t first_y_reg, first_y_next;
    ppa_pkg::coord_t prev_x_reg, prev_x_next;
    ppa_pkg::coord_t prev_y_reg, prev_y_next;
    logic            in_part_reg, in_part_next;
    ppa_pkg::area_t  area_reg, area_next;
    ppa_pkg::perim_t perim_reg, perim_next;
    ppa_pkg::cnt_t   count_reg, count_next;
    logic            ovf_reg, ovf_next;
    logic            close_pend_reg, close_pend_next;
    logic            emit_pend_reg, emit_pend_next;

    // edge operands and arithmetic pipeline
    ppa_pkg::coord_t ex1_reg, ex1_next;
    ppa_pkg::coord_t ey1_reg, ey1_next;
    ppa_pkg::coord_t ex2_reg, ex2_next;
    ppa_pkg::coord_t ey2_reg, ey2_next;
    ppa_pkg::prod_t  prod_reg, prod_next;
    ppa_pkg::prod_t  cross_reg, cross_next;
    ppa_pkg::sq_t    sq_reg, sq_next;

    // output register
    logic             result_valid_reg, result_valid_next;
    ppa_pkg::result_t result_reg, result_next;

    // handshake and shared unit controls
    logic            accept;
    logic            out_free;
    ppa_pkg::diff_t  mul_a, mul_b;
    logic            root_start;
    logic            root_done;
    ppa_pkg::root_t  root_val;
    ppa_pkg::rad_t   radicand;

    // incoming vertex bookkeeping
    ppa_pkg::coord_t vx, vy;
    logic            full;
    logic            take_pt;
    logic            edge1;
    logic            in_part_mid;
    logic            close_now;
    ppa_pkg::coord_t first_x_new, first_y_new, prev_x_new, prev_y_new;

    // edge differences and accumulator helpers
    ppa_pkg::diff_t             dx, dy;
    logic signed [ppa_pkg::AREA_W:0] area_sum_x;
    ppa_pkg::area_t             area_sat;
    logic [ppa_pkg::PERIM_W:0]  perim_sum_x;
    ppa_pkg::perim_t            perim_sat;
    logic [ppa_pkg::AREA_W-1:0] area_mag;
    logic [ppa_pkg::TWICE_W-1:0] twice_val;

    assign vx = ppa_pkg::coord_t'(vertex.x_coord[ppa_pkg::COORD_BITS-1:0]);
    assign vy = ppa_pkg::coord_t'(vertex.y_coord[ppa_pkg::COORD_BITS-1:0]);

    // a vertex past the point limit only marks overflow; its flags still act
    always_comb
    begin
        full        = (count_reg >= ppa_pkg::cnt_t'(ppa_pkg::MAX_POINTS));
        take_pt     = !full;
        edge1       = take_pt && in_part_reg;
        first_x_new = (take_pt && !in_part_reg) ? vx : first_x_reg;
        first_y_new = (take_pt && !in_part_reg) ? vy : first_y_reg;
        prev_x_new  = take_pt ? vx : prev_x_reg;
        prev_y_new  = take_pt ? vy : prev_y_reg;
        in_part_mid = in_part_reg || take_pt;
        close_now   = (vertex.part_last || vertex.polygon_last) && in_part_mid;
    end

    // edge deltas, 21 bits signed
    assign dx = ppa_pkg::diff_t'(ex1_reg) - ppa_pkg::diff_t'(ex2_reg);
    assign dy = ppa_pkg::diff_t'(ey1_reg) - ppa_pkg::diff_t'(ey2_reg);

    // saturating accumulators
    always_comb
    begin
        area_sum_x = {area_reg[ppa_pkg::AREA_W-1], area_reg}
                   + {{(ppa_pkg::AREA_W + 1 - ppa_pkg::PROD_W){cross_reg[ppa_pkg::PROD_W-1]}},
                      cross_reg};
        if (area_sum_x > ppa_pkg::AREA_HI)
            area_sat = ppa_pkg::AREA_HI[ppa_pkg::AREA_W-1:0];
        else if (area_sum_x < ppa_pkg::AREA_LO)
            area_sat = ppa_pkg::AREA_LO[ppa_pkg::AREA_W-1:0];
        else
            area_sat = area_sum_x[ppa_pkg::AREA_W-1:0];

        perim_sum_x = {1'b0, perim_reg} + (ppa_pkg::PERIM_W + 1)'(root_val);
        perim_sat   = perim_sum_x[ppa_pkg::PERIM_W] ? ppa_pkg::PERIM_MAX
                                                   : perim_sum_x[ppa_pkg::PERIM_W-1:0];

        area_mag  = area_reg[ppa_pkg::AREA_W-1] ? (-area_reg) : area_reg;
        twice_val = area_mag[ppa_pkg::AREA_W-1] ? ppa_pkg::TWICE_MAX
                                                : area_mag[ppa_pkg::TWICE_W-1:0];
    end

    // radicand is (dx^2 + dy^2) scaled by the fraction bits, both sides
    assign radicand = ppa_pkg::rad_t'(sq_reg) << (2 * ppa_pkg::FRAC_BITS);

    ppa_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (radicand),
        .done     (root_done),
        .root     (root_val)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ppa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (edge1 || close_now)
                        state_next = ppa_pkg::ST_CROSS_A;
                    else if (vertex.polygon_last)
                        state_next = ppa_pkg::ST_EMIT;
                end
            end
            ppa_pkg::ST_CROSS_A:   state_next = ppa_pkg::ST_CROSS_B;
            ppa_pkg::ST_CROSS_B:   state_next = ppa_pkg::ST_SQ_X;
            ppa_pkg::ST_SQ_X:      state_next = ppa_pkg::ST_SQ_Y;
            ppa_pkg::ST_SQ_Y:      state_next = ppa_pkg::ST_SQ_SUM;
            ppa_pkg::ST_SQ_SUM:    state_next = ppa_pkg::ST_ROOT;
            ppa_pkg::ST_ROOT:      state_next = ppa_pkg::ST_ROOT_WAIT;
            ppa_pkg::ST_ROOT_WAIT:
            begin
                if (root_done)
                begin
                    if (close_pend_reg)
                        state_next = ppa_pkg::ST_CROSS_A;
                    else if (emit_pend_reg)
                        state_next = ppa_pkg::ST_EMIT;
                    else
                        state_next = ppa_pkg::ST_IDLE;
                end
            end
            ppa_pkg::ST_EMIT:
            begin
                if (out_free)
                    state_next = ppa_pkg::ST_IDLE;
            end
            default:      state_next = ppa_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs: handshake and shared multiplier operand select
    always_comb
    begin
        vertex_stall = (state_reg != ppa_pkg::ST_IDLE);
        accept       = vertex_valid && !vertex_stall;
        out_free     = !result_valid_reg || !result_stall;
        root_start   = (state_reg == ppa_pkg::ST_ROOT);
        mul_a        = ppa_pkg::diff_t'(ex1_reg);
        mul_b        = ppa_pkg::diff_t'(ey2_reg);
        unique case (state_reg)
            ppa_pkg::ST_CROSS_B:
            begin
                mul_a = ppa_pkg::diff_t'(ey1_reg);
                mul_b = ppa_pkg::diff_t'(ex2_reg);
            end
            ppa_pkg::ST_SQ_X:
            begin
                mul_a = dx;
                mul_b = dx;
            end
            ppa_pkg::ST_SQ_Y:
            begin
                mul_a = dy;
                mul_b = dy;
            end
            default:
            begin
                mul_a = ppa_pkg::diff_t'(ex1_reg);
                mul_b = ppa_pkg::diff_t'(ey2_reg);
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        first_x_next      = first_x_reg;
        first_y_next      = first_y_reg;
        prev_x_next       = prev_x_reg;
        prev_y_next       = prev_y_reg;
        in_part_next      = in_part_reg;
        area_next         = area_reg;
        perim_next        = perim_reg;
        count_next        = count_reg;
        ovf_next          = ovf_reg;
        close_pend_next   = close_pend_reg;
        emit_pend_next    = emit_pend_reg;
        ex1_next          = ex1_reg;
        ey1_next          = ey1_reg;
        ex2_next          = ex2_reg;
        ey2_next          = ey2_reg;
        prod_next         = mul_a * mul_b;
        cross_next        = cross_reg;
        sq_next           = sq_reg;
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;

        unique case (state_reg)
            ppa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    first_x_next    = first_x_new;
                    first_y_next    = first_y_new;
                    prev_x_next     = prev_x_new;
                    prev_y_next     = prev_y_new;
                    in_part_next    = in_part_mid && !close_now;
                    ovf_next        = ovf_reg || full;
                    count_next      = take_pt ? (count_reg + 1'b1) : count_reg;
                    emit_pend_next  = vertex.polygon_last;
                    close_pend_next = edge1 && close_now;
                    if (edge1)
                    begin
                        // edge from the previous vertex to this one
                        ex1_next = prev_x_reg;
                        ey1_next = prev_y_reg;
                        ex2_next = vx;
                        ey2_next = vy;
                    end
                    else
                    begin
                        // only the closing edge, if any
                        ex1_next = prev_x_new;
                        ey1_next = prev_y_new;
                        ex2_next = first_x_new;
                        ey2_next = first_y_new;
                    end
                end
            end
            ppa_pkg::ST_CROSS_B:
                cross_next = prod_reg;
            ppa_pkg::ST_SQ_X:
                cross_next = cross_reg - prod_reg;
            ppa_pkg::ST_SQ_Y:
            begin
                area_next = area_sat;
                sq_next   = {1'b0, prod_reg[ppa_pkg::SQ_W-2:0]};
            end
            ppa_pkg::ST_SQ_SUM:
                sq_next = sq_reg + {1'b0, prod_reg[ppa_pkg::SQ_W-2:0]};
            ppa_pkg::ST_ROOT_WAIT:
            begin
                if (root_done)
                begin
                    perim_next = perim_sat;
                    if (close_pend_reg)
                    begin
                        // closing edge back to the first vertex of the part
                        close_pend_next = 1'b0;
                        ex1_next        = prev_x_reg;
                        ey1_next        = prev_y_reg;
                        ex2_next        = first_x_reg;
                        ey2_next        = first_y_reg;
                    end
                end
            end
            ppa_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    result_valid_next      = 1'b1;
                    result_next.perimeter  = perim_reg;
                    result_next.twice_area = twice_val;
                    result_next.overflow   = ovf_reg;
                    // polygon done: back to the reset picture
                    first_x_next   = '0;
                    first_y_next   = '0;
                    prev_x_next    = '0;
                    prev_y_next    = '0;
                    in_part_next   = 1'b0;
                    area_next      = '0;
                    perim_next     = '0;
                    count_next     = '0;
                    ovf_next       = 1'b0;
                    emit_pend_next = 1'b0;
                end
            end
            default:
            begin
                cross_next = cross_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ppa_pkg::ST_IDLE;
            first_x_reg      <= '0;
            first_y_reg      <= '0;
            prev_x_reg       <= '0;
            prev_y_reg       <= '0;
            in_part_reg      <= 1'b0;
            area_reg         <= '0;
            perim_reg        <= '0;
            count_reg        <= '0;
            ovf_reg          <= 1'b0;
            close_pend_reg   <= 1'b0;
            emit_pend_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            first_x_reg      <= first_x_next;
            first_y_reg      <= first_y_next;
            prev_x_reg       <= prev_x_next;
            prev_y_reg       <= prev_y_next;
            in_part_reg      <= in_part_next;
            area_reg         <= area_next;
            perim_reg        <= perim_next;
            count_reg        <= count_next;
            ovf_reg          <= ovf_next;
            close_pend_reg   <= close_pend_next;
            emit_pend_reg    <= emit_pend_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        ex1_reg    <= ex1_next;
        ey1_reg    <= ey1_next;
        ex2_reg    <= ex2_next;
        ey2_reg    <= ey2_next;
        prod_reg   <= prod_next;
        cross_reg  <= cross_next;
        sq_reg     <= sq_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // a new result only comes out of the emit step
    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == ppa_pkg::ST_EMIT))
        else $error("result appeared outside the emit step");

    // the root unit only finishes while the sequencer waits for it
    a_root_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        root_done |-> state_reg == ppa_pkg::ST_ROOT_WAIT)
        else $error("root finished while not awaited");

    // point count never passes the limit
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ppa_pkg::cnt_t'(ppa_pkg::MAX_POINTS))
        else $error("point count past limit");

    // after the emit transfer all sums are cleared
    a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ppa_pkg::ST_EMIT && out_free) |=>
            (area_reg == '0 && perim_reg == '0 && !in_part_reg && count_reg == '0))
        else $error("state not cleared after emit");

endmodule

// File: design/ppa_sqrt.sv
// ppa_sqrt: iterative integer square root, one result bit per cycle
// depends on ppa_pkg for radicand and root widths
`timescale 1ns / 1ps

module ppa_sqrt (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  ppa_pkg::rad_t radicand,
    output logic          done,
    output ppa_pkg::root_t root
);

    logic                               busy_reg;
    logic                               done_reg;
    logic [ppa_pkg::ROOT_CNT_W-1:0]     cnt_reg;
    ppa_pkg::rad_t                      rad_reg;
    logic [ppa_pkg::ROOT_W+1:0]         rem_reg;
    ppa_pkg::root_t                     root_reg;

    logic [ppa_pkg::ROOT_W+1:0]         rem_sh;
    logic [ppa_pkg::ROOT_W+1:0]         trial;
    logic                               fits;
    logic [ppa_pkg::ROOT_W+1:0]         rem_next;
    ppa_pkg::root_t                     root_next;

    // bring down two radicand bits, try root*4+1
    always_comb
    begin
        rem_sh    = {rem_reg[ppa_pkg::ROOT_W-1:0], rad_reg[2*ppa_pkg::ROOT_W-1 -: 2]};
        trial     = {root_reg, 2'b01};
        fits      = (rem_sh >= trial);
        rem_next  = fits ? (rem_sh - trial) : rem_sh;
        root_next = {root_reg[ppa_pkg::ROOT_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ppa_pkg::ROOT_CNT_W'(ppa_pkg::ROOT_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
